>>> hw/rtl/papc_pkg.sv
// package for the popup anchor place and clamp block
// widths, mode codes and register indexes; no dependencies
`default_nettype none

package papc_pkg;

	localparam int COORD_BITS = 16;
	localparam int SIZE_BITS = 15;
	localparam int PLACE_BITS = 18;
	// working width: room for three-term sums and the output wrap
	localparam int CALC_BITS = ((COORD_BITS > PLACE_BITS - 2) ? COORD_BITS : PLACE_BITS - 2) + 4;
	localparam int CFG_INDEX_BITS = 1;

	typedef logic signed [CALC_BITS-1:0] calc_t;
	typedef logic [SIZE_BITS-1:0] size_t;

	typedef enum logic [1:0] {
		MODE_BELOW,
		MODE_ABOVE,
		MODE_OFFSET,
		MODE_CENTRE
	} mode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_VIEW_WIDTH,
		CFG_VIEW_HEIGHT
	} cfg_idx_t;

endpackage

`default_nettype wire

>>> hw/rtl/popup_anchor_place_and_clamp_top.sv
// popup anchor placement with flip and viewport clamp, three-stage pipeline
// depends on papc_pkg for widths, mode codes and register indexes
//
// usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes view_width
//    (index 0) or view_height (index 1); cfg_ready is always high. write only
//    while no request is in flight.
//  - req channel takes one placement request per beat when req_valid is high
//    and req_stall is low; rsp channel gives one result beat per request in
//    the same order.
//  - an accepted req beat passes through the three pipeline registers (operand
//    sums, flip/mode select, clamp) to rsp_valid; one beat per cycle sustained
//    while rsp_stall is low.
//  - when rsp_stall is high the result holds on the outputs; bubbles in the
//    pipe still fill, and req_stall rises only once every stage holds a beat.
//  - reset clears the valid bits and both viewport registers to zero, which
//    disables clamping and flips until the viewport is written.
`default_nettype none

module popup_anchor_place_and_clamp_top (
	input  wire                                          clk,
	input  wire                                          arst_n,
	// configuration
	input  wire                                          cfg_valid,
	output logic                                         cfg_ready,
	input  wire  [papc_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
	input  wire  [papc_pkg::SIZE_BITS-1:0]               cfg_data,
	// request
	input  wire                                          req_valid,
	output logic                                         req_stall,
	input  wire  [1:0]                                   mode,
	input  wire  signed [papc_pkg::COORD_BITS-1:0]       off_x,
	input  wire  signed [papc_pkg::COORD_BITS-1:0]       off_y,
	input  wire  [papc_pkg::SIZE_BITS-1:0]               width_override,
	input  wire  [papc_pkg::SIZE_BITS-1:0]               height_override,
	input  wire  signed [papc_pkg::COORD_BITS-1:0]       owner_x,
	input  wire  signed [papc_pkg::COORD_BITS-1:0]       owner_y,
	input  wire  [papc_pkg::SIZE_BITS-1:0]               owner_w,
	input  wire  [papc_pkg::SIZE_BITS-1:0]               owner_h,
	input  wire  [papc_pkg::SIZE_BITS-1:0]               natural_w,
	input  wire  [papc_pkg::SIZE_BITS-1:0]               natural_h,
	// response
	output logic                                         rsp_valid,
	input  wire                                          rsp_stall,
	output logic signed [papc_pkg::PLACE_BITS-1:0]       place_x,
	output logic signed [papc_pkg::PLACE_BITS-1:0]       place_y,
	output logic [papc_pkg::SIZE_BITS-1:0]               place_w,
	output logic [papc_pkg::SIZE_BITS-1:0]               place_h
);
	import papc_pkg::*;

	// viewport registers
	size_t view_width_q, view_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q <= '0;
			view_height_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_VIEW_WIDTH:  view_width_q <= cfg_data;
				CFG_VIEW_HEIGHT: view_height_q <= cfg_data;
			endcase
		end
	end

	calc_t vw, vh;
	assign vw = calc_t'({1'b0, view_width_q});
	assign vh = calc_t'({1'b0, view_height_q});

	// pipeline flow control
	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3 = !rsp_stall || !v_s3;
	assign adv_s2 = adv_s3 || !v_s2;
	assign adv_s1 = adv_s2 || !v_s1;
	assign req_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= req_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: size select and operand sums
	size_t w0, h0;
	calc_t ox0, oy0, own_x0, own_y0, own_h0, h0_c, w0_c;

	always_comb begin
		w0 = (width_override != '0) ? width_override : natural_w;
		h0 = (height_override != '0) ? height_override : natural_h;
		ox0 = calc_t'(off_x);
		oy0 = calc_t'(off_y);
		own_x0 = calc_t'(owner_x);
		own_y0 = calc_t'(owner_y);
		own_h0 = calc_t'({1'b0, owner_h});
		w0_c = calc_t'({1'b0, w0});
		h0_c = calc_t'({1'b0, h0});
	end

	mode_t mode_s1;
	size_t w_s1, h_s1;
	calc_t x_own_s1, x_abs_s1, y_abs_s1, y_below_s1, y_above_s1, bot_end_s1;
	calc_t lim_x_s1, lim_y_s1;
	logic  top_room_s1;

	always_ff @(posedge clk) begin
		if (req_valid && adv_s1) begin
			mode_s1 <= mode_t'(mode);
			w_s1 <= w0;
			h_s1 <= h0;
			x_own_s1 <= own_x0 + ox0;
			x_abs_s1 <= ox0;
			y_abs_s1 <= oy0;
			y_below_s1 <= own_y0 + own_h0 + oy0;
			y_above_s1 <= own_y0 - h0_c - oy0;
			bot_end_s1 <= own_y0 + own_h0 + h0_c;
			top_room_s1 <= !(own_y0 - h0_c < 0);
			lim_x_s1 <= vw - w0_c;
			lim_y_s1 <= vh - h0_c;
		end
	end

	// stage 2: flip decisions, mode select, centre halving
	calc_t x2, y2, h1_c;
	logic  view_h_on;

	assign view_h_on = (view_height_q != '0);
	assign h1_c = calc_t'({1'b0, h_s1});

	always_comb begin
		x2 = x_own_s1;
		y2 = y_below_s1;
		unique case (mode_s1)
			MODE_BELOW: begin
				x2 = x_own_s1;
				if (view_h_on && (y_below_s1 + h1_c > vh) && top_room_s1)
					y2 = y_above_s1;
				else
					y2 = y_below_s1;
			end
			MODE_ABOVE: begin
				x2 = x_own_s1;
				if ((y_above_s1 < 0) && view_h_on && !(bot_end_s1 > vh))
					y2 = y_below_s1;
				else
					y2 = y_above_s1;
			end
			MODE_OFFSET: begin
				x2 = x_abs_s1;
				y2 = y_abs_s1;
			end
			MODE_CENTRE: begin
				// halve toward zero: add one to negative values first
				x2 = (lim_x_s1 + calc_t'(lim_x_s1[CALC_BITS-1])) >>> 1;
				y2 = (lim_y_s1 + calc_t'(lim_y_s1[CALC_BITS-1])) >>> 1;
			end
		endcase
	end

	size_t w_s2, h_s2;
	calc_t x_s2, y_s2, lim_x_s2, lim_y_s2;

	always_ff @(posedge clk) begin
		if (v_s1 && adv_s2) begin
			w_s2 <= w_s1;
			h_s2 <= h_s1;
			x_s2 <= x2;
			y_s2 <= y2;
			lim_x_s2 <= lim_x_s1;
			lim_y_s2 <= lim_y_s1;
		end
	end

	// stage 3: clamp into the viewport; far edge past extent means pos > extent - size
	calc_t xa, ya, xc, yc;

	always_comb begin
		xa = (x_s2 > lim_x_s2) ? lim_x_s2 : x_s2;
		ya = (y_s2 > lim_y_s2) ? lim_y_s2 : y_s2;
		xc = x_s2;
		yc = y_s2;
		if (view_width_q != '0)
			xc = (xa < 0) ? '0 : xa;
		if (view_h_on)
			yc = (ya < 0) ? '0 : ya;
	end

	logic signed [PLACE_BITS-1:0] place_x_s3, place_y_s3;
	size_t place_w_s3, place_h_s3;

	always_ff @(posedge clk) begin
		if (v_s2 && adv_s3) begin
			place_x_s3 <= xc[PLACE_BITS-1:0];
			place_y_s3 <= yc[PLACE_BITS-1:0];
			place_w_s3 <= w_s2;
			place_h_s3 <= h_s2;
		end
	end

	assign rsp_valid = v_s3;
	assign place_x = place_x_s3;
	assign place_y = place_y_s3;
	assign place_w = place_w_s3;
	assign place_h = place_h_s3;

	// an empty first stage always takes a beat
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !req_stall)
		else $error("req_stall high with an empty first stage");

	// a clamped axis never lands left of or above the viewport origin
	a_x_clamped_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (view_width_q != '0) |-> !place_x[PLACE_BITS-1])
		else $error("clamped place_x negative");

	a_y_clamped_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (view_height_q != '0) |-> !place_y[PLACE_BITS-1])
		else $error("clamped place_y negative");

	// along x, a popup that fits keeps its far edge inside the viewport
	a_x_fits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (view_width_q != '0) && (place_w <= view_width_q) |->
		(calc_t'(place_x) + calc_t'({1'b0, place_w}) <= calc_t'({1'b0, view_width_q})))
		else $error("place_x far edge beyond viewport");

endmodule

`default_nettype wire
